// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file tcw_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console check failed");

`endif

// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [OP_W-1:0] OP_PRINT  = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_SETCUR = 3'd2;
  localparam logic [OP_W-1:0] OP_PUT    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'd126;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [7:0]        TAB_MASK   = 8'd3;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_CR,
    CMD_LF,
    CMD_TAB,
    CMD_BS,
    CMD_CHAR,
    CMD_CLEAR,
    CMD_SETCUR,
    CMD_PUT,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ATTR_W-1:0] attr;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0] read_char;
    logic              did_scroll;
  } res_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BS_WRITE,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESULT
  } state_t;

endpackage

// ----- rtl/tcw_fifo.sv -----
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/tcw_front.sv -----
module tcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       hold,
  input  logic                       push,
  output logic                       full,
  input  logic [tcw_pkg::OP_W-1:0]   opcode,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::COL_W-1:0]  col,
  input  logic [tcw_pkg::ROW_W-1:0]  row,
  input  logic [tcw_pkg::ATTR_W-1:0] cell_attr,
  input  logic                       cmd_pop,
  output tcw_pkg::cmd_t              cmd,
  output logic                       cmd_empty
);

  tcw_pkg::cmd_t       cls;
  tcw_pkg::cmd_kind_t  print_kind;
  logic                in_range;
  logic                q_full;
  logic                q_push;

  assign in_range = (int'(col) < COLS) && (int'(row) < ROWS);

  always_comb begin
    unique case (char_code)
      tcw_pkg::CHAR_CR:  print_kind = tcw_pkg::CMD_CR;
      tcw_pkg::CHAR_LF:  print_kind = tcw_pkg::CMD_LF;
      tcw_pkg::CHAR_TAB: print_kind = tcw_pkg::CMD_TAB;
      tcw_pkg::CHAR_BS:  print_kind = tcw_pkg::CMD_BS;
      default: begin
        if (char_code >= tcw_pkg::PRINT_LOW && char_code <= tcw_pkg::PRINT_HIGH) begin
          print_kind = tcw_pkg::CMD_CHAR;
        end else begin
          print_kind = tcw_pkg::CMD_NOP;
        end
      end
    endcase
  end

  // Turn set cursor, put and read at out-of-range positions into no-ops here so the back end never acts on them.
  always_comb begin
    cls.ch   = char_code;
    cls.col  = col;
    cls.row  = row;
    cls.attr = cell_attr;
    unique case (opcode)
      tcw_pkg::OP_PRINT:  cls.kind = print_kind;
      tcw_pkg::OP_CLEAR:  cls.kind = tcw_pkg::CMD_CLEAR;
      tcw_pkg::OP_SETCUR: cls.kind = in_range ? tcw_pkg::CMD_SETCUR : tcw_pkg::CMD_NOP;
      tcw_pkg::OP_PUT:    cls.kind = in_range ? tcw_pkg::CMD_PUT : tcw_pkg::CMD_NOP;
      tcw_pkg::OP_READ:   cls.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_NOP;
      default:            cls.kind = tcw_pkg::CMD_NOP;
    endcase
  end

  assign full   = q_full || hold;
  assign q_push = push && !full;

  tcw_fifo #(
    .WIDTH($bits(tcw_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(cls),
    .full (q_full),
    .pop  (cmd_pop),
    .rdata(cmd),
    .empty(cmd_empty)
  );

endmodule

// ----- rtl/tcw_back.sv -----
module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  tcw_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic          init_busy,
  output tcw_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full
);

  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS << CW;

  tcw_pkg::state_t state, state_next;

  logic [tcw_pkg::COL_W-1:0]  cursor_x, cursor_x_next;
  logic [tcw_pkg::ROW_W-1:0]  cursor_y, cursor_y_next;
  logic [tcw_pkg::ATTR_W-1:0] attr, attr_next;
  logic [RW-1:0]              top, top_next;
  logic [CW-1:0]              sw_col, sw_col_next;
  logic [RW-1:0]              sw_row, sw_row_next;
  logic [tcw_pkg::CHAR_W-1:0] rd, rd_next;
  logic                       scroll, scroll_next;

  logic [tcw_pkg::CELL_W-1:0] mem [0:DEPTH-1];
  logic [tcw_pkg::CELL_W-1:0] rdata;
  logic [tcw_pkg::CELL_W-1:0] wdata;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              cur_addr;
  logic                       we;

  logic                       cmd_valid;
  logic [7:0]                 cx8, tab_x, inc_x;
  logic                       tab_wrap, char_wrap, at_bottom, nl_needed, scroll_go;
  logic [tcw_pkg::ROW_W-1:0]  lrow;
  logic [tcw_pkg::COL_W-1:0]  lcol;
  logic                       sw_last_col, sw_done_all;

  function automatic logic [AW-1:0] cell_addr(
    input logic [tcw_pkg::ROW_W-1:0] r,
    input logic [tcw_pkg::COL_W-1:0] c,
    input logic [RW-1:0]             base
  );
    logic [5:0] sum;
    logic [5:0] prow;
    sum  = 6'(r) + 6'(base);
    prow = (sum >= 6'(ROWS)) ? sum - 6'(ROWS) : sum;
    return {prow[RW-1:0], c[CW-1:0]};
  endfunction

  assign cmd_valid = !cmd_empty;
  assign init_busy = (state == tcw_pkg::ST_INIT);

  assign cx8       = {1'b0, cursor_x};
  assign tab_x     = (cx8 | tcw_pkg::TAB_MASK) + 8'd1;
  assign inc_x     = cx8 + 8'd1;
  assign tab_wrap  = (tab_x >= 8'(COLS));
  assign char_wrap = (inc_x >= 8'(COLS));
  assign at_bottom = (cursor_y == 5'(ROWS - 1));
  assign nl_needed = (cmd.kind == tcw_pkg::CMD_LF)
                  || (cmd.kind == tcw_pkg::CMD_TAB && tab_wrap)
                  || (cmd.kind == tcw_pkg::CMD_CHAR && char_wrap);
  assign scroll_go = nl_needed && at_bottom;

  assign sw_last_col = (sw_col == CW'(COLS - 1));
  assign sw_done_all = sw_last_col && (sw_row == RW'(ROWS - 1));

  // Logical position of the cell touched this cycle.
  always_comb begin
    lrow = cursor_y;
    lcol = cursor_x;
    if (state == tcw_pkg::ST_IDLE) begin
      case (cmd.kind) inside
        tcw_pkg::CMD_PUT, tcw_pkg::CMD_READ: begin
          lrow = cmd.row;
          lcol = cmd.col;
        end
        tcw_pkg::CMD_BS: lcol = cursor_x - 1'b1;
        default: ;
      endcase
    end
  end

  assign cur_addr = cell_addr(lrow, lcol, top);

  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (sw_done_all) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            tcw_pkg::CMD_BS: begin
              state_next = (cursor_x != '0) ? tcw_pkg::ST_BS_WRITE : tcw_pkg::ST_RESULT;
            end
            tcw_pkg::CMD_READ:  state_next = tcw_pkg::ST_READ_WAIT;
            tcw_pkg::CMD_CLEAR: state_next = tcw_pkg::ST_CLEAR;
            default: state_next = scroll_go ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_RESULT;
          endcase
        end
      end
      tcw_pkg::ST_BS_WRITE:  state_next = tcw_pkg::ST_RESULT;
      tcw_pkg::ST_READ_WAIT: state_next = tcw_pkg::ST_RESULT;
      tcw_pkg::ST_SCROLL: begin
        if (sw_last_col) state_next = tcw_pkg::ST_RESULT;
      end
      tcw_pkg::ST_CLEAR: begin
        if (sw_done_all) state_next = tcw_pkg::ST_RESULT;
      end
      tcw_pkg::ST_RESULT: begin
        if (!res_full) state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    attr_next     = attr;
    top_next      = top;
    sw_col_next   = sw_col;
    sw_row_next   = sw_row;
    rd_next       = rd;
    scroll_next   = scroll;
    we            = 1'b0;
    waddr         = cur_addr;
    wdata         = {attr, tcw_pkg::BLANK_CHAR};
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    unique case (state) inside
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR, tcw_pkg::ST_SCROLL: begin
        we          = 1'b1;
        waddr       = {sw_row, sw_col};
        sw_col_next = sw_last_col ? '0 : sw_col + 1'b1;
        if (state != tcw_pkg::ST_SCROLL && sw_last_col) begin
          sw_row_next = sw_row + 1'b1;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          rd_next     = '0;
          scroll_next = scroll_go;
          case (cmd.kind)
            tcw_pkg::CMD_CR: cursor_x_next = '0;
            tcw_pkg::CMD_LF: begin
              if (!at_bottom) cursor_y_next = cursor_y + 1'b1;
            end
            tcw_pkg::CMD_TAB: begin
              if (tab_wrap) begin
                cursor_x_next = '0;
                if (!at_bottom) cursor_y_next = cursor_y + 1'b1;
              end else begin
                cursor_x_next = tab_x[tcw_pkg::COL_W-1:0];
              end
            end
            tcw_pkg::CMD_BS: begin
              if (cursor_x != '0) cursor_x_next = cursor_x - 1'b1;
            end
            tcw_pkg::CMD_CHAR: begin
              we    = 1'b1;
              wdata = {attr, cmd.ch};
              if (char_wrap) begin
                cursor_x_next = '0;
                if (!at_bottom) cursor_y_next = cursor_y + 1'b1;
              end else begin
                cursor_x_next = inc_x[tcw_pkg::COL_W-1:0];
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              attr_next     = cmd.attr;
              cursor_x_next = '0;
              cursor_y_next = '0;
              top_next      = '0;
              sw_col_next   = '0;
              sw_row_next   = '0;
            end
            tcw_pkg::CMD_SETCUR: begin
              cursor_x_next = cmd.col;
              cursor_y_next = cmd.row;
            end
            tcw_pkg::CMD_PUT: begin
              we    = 1'b1;
              wdata = {cmd.attr, cmd.ch};
            end
            default: ;
          endcase
          // Rotate the screen by one row; the old top row becomes the blank bottom row.
          if (scroll_go) begin
            top_next    = (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
            sw_row_next = top;
            sw_col_next = '0;
          end
        end
      end
      tcw_pkg::ST_BS_WRITE: begin
        we    = 1'b1;
        wdata = {rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::BLANK_CHAR};
      end
      tcw_pkg::ST_READ_WAIT: rd_next = rdata[tcw_pkg::CHAR_W-1:0];
      tcw_pkg::ST_RESULT:    res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcw_pkg::ST_INIT;
      cursor_x <= '0;
      cursor_y <= '0;
      attr     <= tcw_pkg::RESET_ATTR;
      top      <= '0;
      sw_col   <= '0;
      sw_row   <= '0;
    end else begin
      state    <= state_next;
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      attr     <= attr_next;
      top      <= top_next;
      sw_col   <= sw_col_next;
      sw_row   <= sw_row_next;
    end
  end

  always_ff @(posedge clk) begin
    rd     <= rd_next;
    scroll <= scroll_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[cur_addr];
  end

  assign res.cursor_col = cursor_x;
  assign res.cursor_row = cursor_y;
  assign res.read_char  = rd;
  assign res.did_scroll = scroll;

endmodule

// ----- rtl/text_console_writer.sv -----
// Channel   Direction  Handshake               Fields
// command   in         push / full             opcode, char_code, col, row, cell_attr
// result    out        pop / empty             cursor_col, cursor_row, read_char, did_scroll
//
// A command waits at most two deep in the front queue; the back end then goes from idle
// straight to its result state for print, set cursor, put and backspace at column 0, and
// through one extra state for other backspaces and read; a scroll adds a sweep of one
// blank row through the single write port. Clear writes every cell.
// After rst the screen memory is swept while full stays high.
// Results wait two deep; a stalled result queue holds the back end in its result state.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [tcw_pkg::OP_W-1:0]   opcode,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::COL_W-1:0]  col,
  input  logic [tcw_pkg::ROW_W-1:0]  row,
  input  logic [tcw_pkg::ATTR_W-1:0] cell_attr,
  output logic                       empty,
  input  logic                       pop,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  output logic [tcw_pkg::CHAR_W-1:0] read_char,
  output logic                       did_scroll
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::res_t res;
  tcw_pkg::res_t res_head;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          init_busy;
  logic          res_push;
  logic          res_full;

  tcw_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (init_busy),
    .push     (push),
    .full     (full),
    .opcode   (opcode),
    .char_code(char_code),
    .col      (col),
    .row      (row),
    .cell_attr(cell_attr),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  tcw_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .init_busy(init_busy),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  tcw_fifo #(
    .WIDTH($bits(tcw_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(res_head),
    .empty(empty)
  );

  assign cursor_col = res_head.cursor_col;
  assign cursor_row = res_head.cursor_row;
  assign read_char  = res_head.read_char;
  assign did_scroll = res_head.did_scroll;

endmodule

// ----- rtl/tcw_checker.sv -----
`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       empty,
  input logic                       pop,
  input logic [tcw_pkg::COL_W-1:0]  cursor_col,
  input logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  input logic [tcw_pkg::CHAR_W-1:0] read_char,
  input logic                       did_scroll
);

  // Cursor always lands inside the grid.
  `TCW_ASSERT_NOW(a_col_in_grid, clk, rst, !empty, int'(cursor_col) < COLS)
  `TCW_ASSERT_NOW(a_row_in_grid, clk, rst, !empty, int'(cursor_row) < ROWS)
  // A scroll leaves the cursor on the last row.
  `TCW_ASSERT_NOW(a_scroll_bottom, clk, rst, !empty && did_scroll,
                  int'(cursor_row) == ROWS - 1)
  // Hold a waiting item until it is taken.
  `TCW_ASSERT_NEXT(a_hold_result, clk, rst, !empty && !pop,
                   !empty && $stable(cursor_col) && $stable(cursor_row)
                   && $stable(read_char) && $stable(did_scroll))

endmodule

bind text_console_writer tcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .cursor_col(cursor_col),
  .cursor_row(cursor_row),
  .read_char (read_char),
  .did_scroll(did_scroll)
);

// ----- test/console_checker.sv -----
module console_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       full,
  input  logic [tcw_pkg::OP_W-1:0]   opcode,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::COL_W-1:0]  col,
  input  logic [tcw_pkg::ROW_W-1:0]  row,
  input  logic [tcw_pkg::ATTR_W-1:0] cell_attr,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [tcw_pkg::COL_W-1:0]  cursor_col,
  input  logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  input  logic [tcw_pkg::CHAR_W-1:0] read_char,
  input  logic                       did_scroll,
  output int                         errors,
  output int                         outstanding
);

  logic [tcw_pkg::CELL_W-1:0] cells [ROWS*COLS];
  int                         cx;
  int                         cy;
  logic [tcw_pkg::ATTR_W-1:0] cur_attr;
  tcw_pkg::res_t              expected_reports [$];
  int                         mismatch_count = 0;

  assign errors = mismatch_count;

  task automatic fill_screen(input logic [tcw_pkg::ATTR_W-1:0] attr);
    for (int i = 0; i < ROWS*COLS; i++) cells[i] = {attr, tcw_pkg::BLANK_CHAR};
  endtask

  task automatic scroll_screen();
    for (int i = 0; i < (ROWS-1)*COLS; i++) cells[i] = cells[i+COLS];
    for (int i = 0; i < COLS; i++) cells[(ROWS-1)*COLS+i] = {cur_attr, tcw_pkg::BLANK_CHAR};
  endtask

  task automatic line_feed(output logic scrolled);
    scrolled = 1'b0;
    cy++;
    if (cy >= ROWS) begin
      scroll_screen();
      cy = ROWS - 1;
      scrolled = 1'b1;
    end
  endtask

  task automatic wrap_column(output logic scrolled);
    scrolled = 1'b0;
    if (cx >= COLS) begin
      cx = 0;
      line_feed(scrolled);
    end
  endtask

  task automatic print_char(input logic [tcw_pkg::CHAR_W-1:0] ch, output logic scrolled);
    int idx;
    idx = cy*COLS + cx;
    scrolled = 1'b0;
    if (ch == tcw_pkg::CHAR_CR) begin
      cx = 0;
    end else if (ch == tcw_pkg::CHAR_LF) begin
      line_feed(scrolled);
    end else if (ch == tcw_pkg::CHAR_TAB) begin
      do cx++; while ((cx & tcw_pkg::TAB_MASK) != 0 && cx < COLS);
      wrap_column(scrolled);
    end else if (ch == tcw_pkg::CHAR_BS) begin
      if (cx > 0) begin
        cx--;
        cells[cy*COLS + cx][tcw_pkg::CHAR_W-1:0] = tcw_pkg::BLANK_CHAR;
      end
    end else if (ch >= tcw_pkg::PRINT_LOW && ch <= tcw_pkg::PRINT_HIGH) begin
      cells[idx] = {cur_attr, ch};
      cx++;
      wrap_column(scrolled);
    end
  endtask

  task automatic run_console_op(input logic [tcw_pkg::OP_W-1:0] op,
                                input logic [tcw_pkg::CHAR_W-1:0] ch,
                                input logic [tcw_pkg::COL_W-1:0] c,
                                input logic [tcw_pkg::ROW_W-1:0] r,
                                input logic [tcw_pkg::ATTR_W-1:0] a,
                                output tcw_pkg::res_t report);
    logic on_screen;
    logic scrolled;
    on_screen = (c < COLS) && (r < ROWS);
    scrolled = 1'b0;
    report.read_char = '0;
    case (op)
      tcw_pkg::OP_PRINT: print_char(ch, scrolled);
      tcw_pkg::OP_CLEAR: begin
        cur_attr = a;
        cx = 0;
        cy = 0;
        fill_screen(a);
      end
      tcw_pkg::OP_SETCUR: begin
        if (on_screen) begin
          cx = int'(c);
          cy = int'(r);
        end
      end
      tcw_pkg::OP_PUT: begin
        if (on_screen) cells[r*COLS + c] = {a, ch};
      end
      tcw_pkg::OP_READ: begin
        if (on_screen) report.read_char = cells[r*COLS + c][tcw_pkg::CHAR_W-1:0];
      end
      default: ;
    endcase
    report.cursor_col = cx[tcw_pkg::COL_W-1:0];
    report.cursor_row = cy[tcw_pkg::ROW_W-1:0];
    report.did_scroll = scrolled;
  endtask

  always @(posedge clk) begin : monitor
    tcw_pkg::res_t want;
    tcw_pkg::res_t got;
    if (rst) begin
      cx = 0;
      cy = 0;
      cur_attr = tcw_pkg::RESET_ATTR;
      fill_screen(tcw_pkg::RESET_ATTR);
      expected_reports.delete();
    end else begin
      if (pop && !empty) begin
        got.cursor_col = cursor_col;
        got.cursor_row = cursor_row;
        got.read_char  = read_char;
        got.did_scroll = did_scroll;
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result: col %0d row %0d char %02h scroll %0b",
                     $realtime, got.cursor_col, got.cursor_row, got.read_char, got.did_scroll);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected col %0d row %0d char %02h scroll %0b",
                       $realtime, want.cursor_col, want.cursor_row, want.read_char,
                       want.did_scroll);
              $display("%0t: actual   col %0d row %0d char %02h scroll %0b",
                       $realtime, got.cursor_col, got.cursor_row, got.read_char,
                       got.did_scroll);
            end
          end
        end
      end
      if (push && !full) begin
        run_console_op(opcode, char_code, col, row, cell_attr, want);
        expected_reports.push_back(want);
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

// ----- test/testbench.sv -----
module testbench;

  localparam int COLS         = 80;
  localparam int ROWS         = 25;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 20000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [tcw_pkg::OP_W-1:0]   opcode = '0;
  logic [tcw_pkg::CHAR_W-1:0] char_code = '0;
  logic [tcw_pkg::COL_W-1:0]  col = '0;
  logic [tcw_pkg::ROW_W-1:0]  row = '0;
  logic [tcw_pkg::ATTR_W-1:0] cell_attr = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::CHAR_W-1:0] read_char;
  logic                       did_scroll;
  int                         errors;
  int                         outstanding;
  int                         items_sent = 0;
  int                         burst_left = 0;
  int                         idle_cycles = 0;

  text_console_writer #(.COLS(COLS), .ROWS(ROWS)) u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .char_code(char_code), .col(col), .row(row), .cell_attr(cell_attr),
    .empty(empty), .pop(pop), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .read_char(read_char), .did_scroll(did_scroll)
  );

  console_checker #(.COLS(COLS), .ROWS(ROWS)) u_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .char_code(char_code), .col(col), .row(row), .cell_attr(cell_attr),
    .empty(empty), .pop(pop), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .read_char(read_char), .did_scroll(did_scroll), .errors(errors),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item, sometimes after a random idle gap, and hold it until the block takes it.
  task automatic send_cmd(input logic [tcw_pkg::OP_W-1:0] op,
                          input logic [tcw_pkg::CHAR_W-1:0] ch,
                          input logic [tcw_pkg::COL_W-1:0] c,
                          input logic [tcw_pkg::ROW_W-1:0] r,
                          input logic [tcw_pkg::ATTR_W-1:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push      <= 1'b1;
    opcode    <= op;
    char_code <= ch;
    col       <= c;
    row       <= r;
    cell_attr <= a;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  initial begin : stimulus
    logic [tcw_pkg::OP_W-1:0]   op;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::COL_W-1:0]  c;
    logic [tcw_pkg::ROW_W-1:0]  r;
    logic [tcw_pkg::ATTR_W-1:0] a;
    int                         pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_cmd(tcw_pkg::OP_READ,   8'h00, 7'd0,   5'd0,  8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  8'h41, 7'd0,   5'd0,  8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::PRINT_LOW,  7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::PRINT_HIGH, 7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  8'd31, 7'd0,   5'd0,  8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  8'd127, 7'd0,  5'd0,  8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  8'hFF, 7'h7F,  5'h1F, 8'hFF);
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::CHAR_TAB, 7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::CHAR_BS,  7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::CHAR_CR,  7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::CHAR_BS,  7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::CHAR_LF,  7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_SETCUR, 8'h00, 7'd79,  5'd24, 8'h00);
    // print in the bottom right corner: wrap and scroll
    send_cmd(tcw_pkg::OP_PRINT,  8'h7A, 7'd0,   5'd0,  8'h00);
    send_cmd(tcw_pkg::OP_SETCUR, 8'h00, 7'd80,  5'd0,  8'h00);
    send_cmd(tcw_pkg::OP_SETCUR, 8'h00, 7'd78,  5'd24, 8'h00);
    // tab from column 78 reaches the edge and scrolls
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::CHAR_TAB, 7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_PRINT,  tcw_pkg::CHAR_LF,  7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_PUT,    8'hFF, 7'd79,  5'd24, 8'hFF);
    send_cmd(tcw_pkg::OP_PUT,    8'h55, 7'd0,   5'd25, 8'h00);
    send_cmd(tcw_pkg::OP_READ,   8'h00, 7'd79,  5'd24, 8'h00);
    send_cmd(tcw_pkg::OP_READ,   8'h00, 7'h7F,  5'h1F, 8'h00);
    send_cmd(tcw_pkg::OP_CLEAR,  8'h00, 7'd0,   5'd0,  8'hFF);
    send_cmd(tcw_pkg::OP_READ + 3'd1, 8'h00, 7'd0, 5'd0, 8'h00);
    send_cmd(tcw_pkg::OP_READ + 3'd3, 8'hFF, 7'h7F, 5'h1F, 8'hFF);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      ch = 8'($urandom_range(0, 255));
      c  = 7'($urandom_range(0, 127));
      r  = 5'($urandom_range(0, 31));
      a  = 8'($urandom_range(0, 255));
      if (pick < 55) begin
        op = tcw_pkg::OP_PRINT;
        case ($urandom_range(0, 9))
          0: ch = tcw_pkg::CHAR_CR;
          1: ch = tcw_pkg::CHAR_LF;
          2: ch = tcw_pkg::CHAR_TAB;
          3: ch = tcw_pkg::CHAR_BS;
          4: ;
          default: ch = 8'($urandom_range(tcw_pkg::PRINT_LOW, tcw_pkg::PRINT_HIGH));
        endcase
      end else if (pick < 92) begin
        op = (pick < 65) ? tcw_pkg::OP_SETCUR : (pick < 78) ? tcw_pkg::OP_PUT : tcw_pkg::OP_READ;
        // keep most positions on screen, biased toward the bottom rows
        if ($urandom_range(0, 9) != 0) begin
          c = 7'($urandom_range(0, COLS-1));
          r = 5'($urandom_range(0, 1) ? $urandom_range(ROWS-3, ROWS-1)
                                      : $urandom_range(0, ROWS-1));
          if (op == tcw_pkg::OP_SETCUR && $urandom_range(0, 2) == 0)
            c = 7'($urandom_range(COLS-6, COLS-1));
        end
      end else if (pick < 94) begin
        op = tcw_pkg::OP_CLEAR;
      end else begin
        op = tcw_pkg::OP_READ + 3'($urandom_range(1, 3));
      end
      send_cmd(op, ch, c, r, a);
    end

    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int recv_cyc;
    int holds_done;
    recv_cyc = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      recv_cyc++;
      if (rst) begin
        pop <= 1'b0;
      end else if ((holds_done == 0 && items_sent >= 150) ||
                   (holds_done == 1 && items_sent >= 420)) begin
        // hold off long enough for the block to fill and stall its input
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        case ((recv_cyc / 97) % 4)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (recv_cyc % 5) != 0;
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

// ----- text_console_writer.f -----
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_fifo.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
test/console_checker.sv
test/testbench.sv
